// ===== rtl/core/hbb_pkg.sv =====
// hbb_pkg: shared constants, types and register codes of the horizontal box blur
// used by every module under rtl/core, depends on nothing
package hbb_pkg;

    localparam int MAX_BLUR    = 64;
    localparam int IDX_W       = $clog2(MAX_BLUR);
    localparam int LEN_W       = IDX_W + 1;
    localparam int MAX_WIDTH   = 4096;
    localparam int COL_W       = $clog2(MAX_WIDTH) + 1;
    localparam int NUM_LANES   = 4;
    localparam int SAMPLE_W    = 8;
    localparam int SUM_W       = SAMPLE_W + IDX_W;
    localparam int MAX_RESULTS = 33;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);
    localparam int DIV_STEPS   = SAMPLE_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;
    localparam int CHAN_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_BLUR_LENGTH   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'd1;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef sample_t [NUM_LANES-1:0] pixel_t;
    typedef logic [SUM_W-1:0] sum_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        pixel_t           pix;
    } ring_wr_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        pixel_t           pix;
    } ring_rd_t;

    typedef struct packed {
        logic                   start;
        logic [LEN_W-1:0]       divisor;
        sum_t [NUM_LANES-1:0]   dividend;
    } div_req_t;

    typedef struct packed {
        logic   done;
        pixel_t quotient;
    } div_rsp_t;

endpackage

// ===== rtl/core/hbb_cell.sv =====
// hbb_cell: one pixel slot of the rotating window ring
// takes its neighbor's pixel each cycle unless loaded, cleared at reset, depends on hbb_pkg
module hbb_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  hbb_pkg::pixel_t load_pix,
    input  hbb_pkg::pixel_t shift_in,
    output hbb_pkg::pixel_t pix_out
);
    import hbb_pkg::*;

    pixel_t pix_reg;
    pixel_t pix_next;

    always_comb begin
        pix_next = load ? load_pix : shift_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_reg <= '0;
        end else begin
            pix_reg <= pix_next;
        end
    end

    assign pix_out = pix_reg;

endmodule

// ===== rtl/core/hbb_ring.sv =====
// hbb_ring: ring of MAX_BLUR cells holding the window store, rotating every cycle
// head cell and its store index form the read port, depends on hbb_pkg and hbb_cell
module hbb_ring (
    input  logic              aclk,
    input  logic              aresetn,
    input  hbb_pkg::ring_wr_t wr,
    output hbb_pkg::ring_rd_t rd
);
    import hbb_pkg::*;

    logic [IDX_W-1:0] rot_reg;
    logic [IDX_W-1:0] rot_next;
    logic [IDX_W-1:0] load_pos;
    pixel_t           chain [MAX_BLUR];

    // store index at cell k after the shift is rot + 1 + k
    assign load_pos = wr.idx - rot_reg - IDX_W'(1);
    assign rot_next = rot_reg + IDX_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_reg <= '0;
        end else begin
            rot_reg <= rot_next;
        end
    end

    for (genvar k = 0; k < MAX_BLUR; k++) begin : g_cell
        localparam int NXT = (k + 1) % MAX_BLUR;
        hbb_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .load     (wr.en && (load_pos == IDX_W'(k))),
            .load_pix (wr.pix),
            .shift_in (chain[NXT]),
            .pix_out  (chain[k])
        );
    end

    assign rd.idx = rot_reg;
    assign rd.pix = chain[0];

endmodule

// ===== rtl/core/hbb_div.sv =====
// hbb_div: four-lane restoring divider, one quotient bit per cycle
// quotient is known to fit a sample, depends on hbb_pkg
module hbb_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  hbb_pkg::div_req_t req,
    output hbb_pkg::div_rsp_t rsp
);
    import hbb_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [LEN_W-1:0]  divisor_reg;
    logic [LEN_W-1:0]  divisor_next;
    logic [LEN_W-1:0]  rem_reg  [NUM_LANES];
    logic [LEN_W-1:0]  rem_next [NUM_LANES];
    pixel_t            quo_reg;
    pixel_t            quo_next;

    always_comb begin
        logic [LEN_W:0] trial [NUM_LANES];
        logic [LEN_W:0] diff  [NUM_LANES];
        logic           ge    [NUM_LANES];
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        divisor_next = divisor_reg;
        quo_next     = quo_reg;
        for (int l = 0; l < NUM_LANES; l++) begin
            trial[l]    = {rem_reg[l], quo_reg[l][SAMPLE_W-1]};
            diff[l]     = trial[l] - {1'b0, divisor_reg};
            ge[l]       = trial[l] >= {1'b0, divisor_reg};
            rem_next[l] = rem_reg[l];
        end
        if (req.start) begin
            busy_next    = 1'b1;
            step_next    = '0;
            divisor_next = req.divisor;
            for (int l = 0; l < NUM_LANES; l++) begin
                rem_next[l] = LEN_W'(req.dividend[l][SUM_W-1:SAMPLE_W]);
                quo_next[l] = req.dividend[l][SAMPLE_W-1:0];
            end
        end else if (busy_reg) begin
            step_next = step_reg + STEP_W'(1);
            for (int l = 0; l < NUM_LANES; l++) begin
                rem_next[l] = ge[l] ? diff[l][LEN_W-1:0] : trial[l][LEN_W-1:0];
                quo_next[l] = {quo_reg[l][SAMPLE_W-2:0], ge[l]};
            end
            if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg    <= step_next;
        divisor_reg <= divisor_next;
        quo_reg     <= quo_next;
        for (int l = 0; l < NUM_LANES; l++) begin
            rem_reg[l] <= rem_next[l];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/core/horizontal_box_blur.sv =====
// horizontal_box_blur: top level, request sequencer, window sums and output register
// depends on hbb_pkg, hbb_ring (hbb_cell) and hbb_div
//
// Usage: pixels come in on the s_ channel, one request per pixel with four 8-bit
// samples and a row_end flag. Each request yields zero or more blurred pixels on
// the m_ channel (at most 33); m_run_last marks the last of them and m_row_last
// the final pixel of a row. Registers are written over the cfg_ channel, which
// is always ready: index 0 is blur_length, index 1 is channel_count.
// One request is worked at a time. The request is written into the window ring
// in the cycle it is accepted; each result then passes one check, a full turn
// of the ring to form the four window sums, one divider start, 8 divider steps
// and the divider done, and one output load. Most of the time per result goes
// to the ring turn.
// A stalled receiver holds the sequencer in its output load; a finished result
// waits in the output register while the next request is taken.
// Reset clears the row position, the output valid and the pixel store and sets
// blur_length to 1 and channel_count to 3.
module horizontal_box_blur (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hbb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hbb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [hbb_pkg::SAMPLE_W-1:0]     s_in_c0,
    input  logic [hbb_pkg::SAMPLE_W-1:0]     s_in_c1,
    input  logic [hbb_pkg::SAMPLE_W-1:0]     s_in_c2,
    input  logic [hbb_pkg::SAMPLE_W-1:0]     s_in_c3,
    input  logic                             s_row_end,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [hbb_pkg::SAMPLE_W-1:0]     m_out_c0,
    output logic [hbb_pkg::SAMPLE_W-1:0]     m_out_c1,
    output logic [hbb_pkg::SAMPLE_W-1:0]     m_out_c2,
    output logic [hbb_pkg::SAMPLE_W-1:0]     m_out_c3,
    output logic                             m_row_last,
    output logic                             m_run_last
);
    import hbb_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_ACC    = 3'd2;
    localparam logic [2:0] ST_DSTART = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    // control state
    logic [2:0]            state_reg, state_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [COL_W-1:0]      emit_reg, emit_next;
    logic [RES_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      acc_cnt_reg, acc_cnt_next;
    logic                  m_valid_reg, m_valid_next;
    logic [CFG_DATA_W-1:0] blur_len_reg, blur_len_next;
    logic [CHAN_W-1:0]     chan_reg, chan_next;

    // per request and per result working values
    logic [COL_W-1:0]      n_reg, n_next;
    logic                  end_reg, end_next;
    logic [IDX_W-1:0]      lo_idx_reg, lo_idx_next;
    logic [LEN_W-1:0]      rlen_reg, rlen_next;
    logic [IDX_W-1:0]      cl_reg, cl_next;
    logic [IDX_W-1:0]      cr_reg, cr_next;
    logic                  last_reg, last_next;
    sum_t [NUM_LANES-1:0]  sum_reg, sum_next;
    pixel_t                m_pix_reg, m_pix_next;
    logic                  m_row_last_reg, m_row_last_next;
    logic                  m_run_last_reg, m_run_last_next;

    // window shape from blur_length, active lanes from channel_count
    logic [LEN_W-1:0]      len_clamp;
    logic [LEN_W-1:0]      win_len;
    logic [IDX_W-1:0]      lh;
    logic [IDX_W-1:0]      rh;
    logic [CHAN_W-1:0]     active;

    ring_wr_t              ring_wr;
    ring_rd_t              ring_rd;
    div_req_t              div_req;
    div_rsp_t              div_rsp;

    logic                  s_fire;
    logic                  out_free;

    hbb_ring u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (ring_wr),
        .rd      (ring_rd)
    );

    hbb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        len_clamp = (blur_len_reg > CFG_DATA_W'(MAX_BLUR)) ? LEN_W'(MAX_BLUR)
                                                          : LEN_W'(blur_len_reg);
        if (len_clamp < LEN_W'(2)) begin
            win_len = LEN_W'(1);
            lh      = '0;
            rh      = '0;
        end else begin
            win_len = len_clamp;
            lh      = len_clamp[LEN_W-1:1];
            rh      = len_clamp[0] ? len_clamp[LEN_W-1:1]
                                   : len_clamp[LEN_W-1:1] - IDX_W'(1);
        end
        active = (chan_reg > CHAN_W'(NUM_LANES)) ? CHAN_W'(NUM_LANES) : chan_reg;
    end

    assign ring_wr.en  = s_fire;
    assign ring_wr.idx = col_reg[IDX_W-1:0];
    assign ring_wr.pix = {s_in_c3, s_in_c2, s_in_c1, s_in_c0};

    assign div_req.start    = (state_reg == ST_DSTART);
    assign div_req.divisor  = win_len;
    assign div_req.dividend = sum_reg;

    always_comb begin
        logic [COL_W:0]         xw;
        logic [COL_W:0]         x1w;
        logic [COL_W:0]         nw;
        logic [COL_W:0]         lhw;
        logic [COL_W:0]         rhw;
        logic [COL_W:0]         xr;
        logic [COL_W:0]         lo;
        logic [COL_W:0]         hi;
        logic [COL_W:0]         span;
        logic [COL_W:0]         dl;
        logic [COL_W:0]         dr;
        logic [RES_W-1:0]       c1;
        logic                   due_now;
        logic                   due_next;
        logic [IDX_W-1:0]       head_ofs;
        logic                   in_range;
        logic [LEN_W-1:0]       weight;
        logic [SUM_W+LEN_W-1:0] prod;

        state_next      = state_reg;
        col_next        = col_reg;
        emit_next       = emit_reg;
        count_next      = count_reg;
        acc_cnt_next    = acc_cnt_reg;
        m_valid_next    = m_valid_reg;
        blur_len_next   = blur_len_reg;
        chan_next       = chan_reg;
        n_next          = n_reg;
        end_next        = end_reg;
        lo_idx_next     = lo_idx_reg;
        rlen_next       = rlen_reg;
        cl_next         = cl_reg;
        cr_next         = cr_reg;
        last_next       = last_reg;
        sum_next        = sum_reg;
        m_pix_next      = m_pix_reg;
        m_row_last_next = m_row_last_reg;
        m_run_last_next = m_run_last_reg;

        xw   = {1'b0, emit_reg};
        x1w  = xw + (COL_W+1)'(1);
        nw   = {1'b0, n_reg};
        lhw  = (COL_W+1)'(lh);
        rhw  = (COL_W+1)'(rh);
        xr   = xw + rhw;
        lo   = (xw >= lhw) ? xw - lhw : '0;
        hi   = (xr > nw) ? nw : xr;
        span = hi - lo;
        dl   = lhw - xw;
        dr   = xr - nw;
        c1   = count_reg + RES_W'(1);

        due_now  = (count_reg < RES_W'(MAX_RESULTS))
                   && (end_reg ? (xw <= nw) : (xr <= nw));
        due_next = (c1 < RES_W'(MAX_RESULTS))
                   && (end_reg ? (x1w <= nw) : (x1w + rhw <= nw));

        // weight of the store entry now at the ring head
        head_ofs = ring_rd.idx - lo_idx_reg;
        in_range = {1'b0, head_ofs} < rlen_reg;
        weight   = LEN_W'(in_range)
                   + ((ring_rd.idx == '0) ? {1'b0, cl_reg} : '0)
                   + ((ring_rd.idx == n_reg[IDX_W-1:0]) ? {1'b0, cr_reg} : '0);
        prod     = '0;

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_BLUR_LENGTH:   blur_len_next = cfg_data;
                REG_CHANNEL_COUNT: chan_next     = cfg_data[CHAN_W-1:0];
                default:           blur_len_next = blur_len_reg;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    n_next     = col_reg;
                    end_next   = s_row_end || (col_reg >= COL_W'(MAX_WIDTH - 1));
                    count_next = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (due_now) begin
                    lo_idx_next  = lo[IDX_W-1:0];
                    rlen_next    = {1'b0, span[IDX_W-1:0]} + LEN_W'(1);
                    cl_next      = (xw < lhw) ? dl[IDX_W-1:0] : '0;
                    cr_next      = (xr > nw) ? dr[IDX_W-1:0] : '0;
                    last_next    = !due_next;
                    sum_next     = '0;
                    acc_cnt_next = '0;
                    state_next   = ST_ACC;
                end else begin
                    if (end_reg) begin
                        col_next  = '0;
                        emit_next = '0;
                    end else begin
                        col_next  = n_reg + COL_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_ACC: begin
                for (int l = 0; l < NUM_LANES; l++) begin
                    prod        = (SUM_W+LEN_W)'(ring_rd.pix[l]) * (SUM_W+LEN_W)'(weight);
                    sum_next[l] = sum_reg[l] + prod[SUM_W-1:0];
                end
                acc_cnt_next = acc_cnt_reg + IDX_W'(1);
                if (acc_cnt_reg == IDX_W'(MAX_BLUR - 1)) begin
                    state_next = ST_DSTART;
                end
            end
            ST_DSTART: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    for (int l = 0; l < NUM_LANES; l++) begin
                        m_pix_next[l] = (CHAN_W'(l) < active) ? div_rsp.quotient[l] : '0;
                    end
                    m_row_last_next = end_reg && last_reg;
                    m_run_last_next = last_reg;
                    m_valid_next    = 1'b1;
                    count_next      = c1;
                    emit_next       = emit_reg + COL_W'(1);
                    state_next      = ST_CHECK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            col_reg      <= '0;
            emit_reg     <= '0;
            count_reg    <= '0;
            acc_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
            blur_len_reg <= CFG_DATA_W'(1);
            chan_reg     <= CHAN_W'(3);
            end_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            emit_reg     <= emit_next;
            count_reg    <= count_next;
            acc_cnt_reg  <= acc_cnt_next;
            m_valid_reg  <= m_valid_next;
            blur_len_reg <= blur_len_next;
            chan_reg     <= chan_next;
            end_reg      <= end_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg          <= n_next;
        lo_idx_reg     <= lo_idx_next;
        rlen_reg       <= rlen_next;
        cl_reg         <= cl_next;
        cr_reg         <= cr_next;
        last_reg       <= last_next;
        sum_reg        <= sum_next;
        m_pix_reg      <= m_pix_next;
        m_row_last_reg <= m_row_last_next;
        m_run_last_reg <= m_run_last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_c0   = m_pix_reg[0];
    assign m_out_c1   = m_pix_reg[1];
    assign m_out_c2   = m_pix_reg[2];
    assign m_out_c3   = m_pix_reg[3];
    assign m_row_last = m_row_last_reg;
    assign m_run_last = m_run_last_reg;

endmodule
